@@ hw/rtl/srs_pkg.sv @@
`default_nettype none
package srs_pkg;

   localparam int MAX_WINDOW  = 16;
   localparam int SLOT_AW     = $clog2(MAX_WINDOW);
   localparam int QUEUE_DEPTH = 1024;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int PKT_W       = 160;
   localparam int SUM_GROUPS  = PKT_W / 32;

   localparam logic [1:0] OP_MSG     = 2'd0;
   localparam logic [1:0] OP_ACK     = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   localparam logic [2:0] KIND_SEND      = 3'd0;
   localparam logic [2:0] KIND_RESEND    = 3'd1;
   localparam logic [2:0] KIND_QUEUED    = 3'd2;
   localparam logic [2:0] KIND_DROPPED   = 3'd3;
   localparam logic [2:0] KIND_CORRUPT   = 3'd4;
   localparam logic [2:0] KIND_ACK       = 3'd5;
   localparam logic [2:0] KIND_UNMATCHED = 3'd6;

   localparam logic [4:0]  WINDOW_RESET = 5'd8;
   localparam logic [15:0] CKS_GOOD     = 16'hFFFF;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SUM, S_FOLD_SEQ, S_FOLD_SEQN, S_FOLD_ACKN, S_FOLD_PCKS,
      S_CHECK, S_ACK_SCAN, S_SLIDE, S_T_SCAN, S_T_LOAD, S_Q_READ, S_Q_LOAD, S_EMIT
   } state_type;

   typedef enum logic [2:0] {
      FOLD_NEXT, FOLD_TSEQ, FOLD_SEQN, FOLD_ACKN, FOLD_PCKS
   } fold_sel_type;

   typedef enum logic [1:0] {
      LOAD_NONE, LOAD_INPUT, LOAD_SLOT, LOAD_QUEUE
   } load_sel_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] seq_number;
      logic [15:0] ack_number;
      logic [15:0] packet_checksum;
      logic [15:0] timeout_seq;
      logic [63:0] payload_low;
      logic [63:0] payload_mid;
      logic [31:0] payload_high;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] seq_out;
      logic [15:0] checksum_out;
      logic [63:0] data_low;
      logic [63:0] data_mid;
      logic [31:0] data_high;
      logic [15:0] window_base;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      load_sel_type load_sel;
      logic         sum_step;
      logic         fold;
      fold_sel_type fold_sel;
      logic         scan_step;
      logic         mark_ack;
      logic         slide;
      logic         q_pop;
      logic         emit;
      logic [2:0]   kind;
      logic         last;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       win_ok;
      logic       q_full;
      logic       sum_last;
      logic       ack_good;
      logic       scan_done;
      logic       scan_hit;
      logic       base_eq;
      logic       slide_ok;
      logic       drain_pending;
      logic       drain_more;
      logic       out_free;
   } status_type;

endpackage
`default_nettype wire

@@ hw/rtl/srs_req_if.sv @@
`default_nettype none
interface srs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] seq_number;
   logic [15:0] ack_number;
   logic [15:0] packet_checksum;
   logic [15:0] timeout_seq;
   logic [63:0] payload_low;
   logic [63:0] payload_mid;
   logic [31:0] payload_high;

   modport source (output valid, op, seq_number, ack_number, packet_checksum, timeout_seq,
                   payload_low, payload_mid, payload_high, input ready);
   modport sink (input valid, op, seq_number, ack_number, packet_checksum, timeout_seq,
                 payload_low, payload_mid, payload_high, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/srs_rsp_if.sv @@
`default_nettype none
interface srs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] seq_out;
   logic [15:0] checksum_out;
   logic [63:0] data_low;
   logic [63:0] data_mid;
   logic [31:0] data_high;
   logic [15:0] window_base;
   logic        last;

   modport source (output valid, kind, seq_out, checksum_out, data_low, data_mid, data_high,
                   window_base, last, input ready);
   modport sink (input valid, kind, seq_out, checksum_out, data_low, data_mid, data_high,
                 window_base, last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/srs_ctrl.sv @@
`default_nettype none
module srs_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire srs_pkg::status_type st,
   output srs_pkg::cmd_type        cmd
);

   srs_pkg::state_type state_ff, state_in;
   logic [2:0]         kind_ff, kind_in;
   logic               drain_ff, drain_in;
   logic               ack_base_ff, ack_base_in;
   logic               last;

   // Only ack results and sends out of the queue can be followed by more sends.
   // An acknowledgment drains the queue only when it matched the window base.
   always_comb begin
      if (kind_ff == srs_pkg::KIND_ACK) begin
         last = !(ack_base_ff && st.drain_pending);
      end else if (kind_ff == srs_pkg::KIND_SEND && drain_ff) begin
         last = !st.drain_more;
      end else begin
         last = 1'b1;
      end
   end

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      drain_in    = drain_ff;
      ack_base_in = ack_base_ff;
      case (state_ff)
         srs_pkg::S_IDLE: begin
            drain_in    = 1'b0;
            ack_base_in = 1'b0;
            if (req_valid) state_in = srs_pkg::S_DECODE;
         end
         srs_pkg::S_DECODE: begin
            case (st.op)
               srs_pkg::OP_MSG: begin
                  if (st.win_ok) begin
                     state_in = srs_pkg::S_SUM;
                  end else begin
                     kind_in  = st.q_full ? srs_pkg::KIND_DROPPED : srs_pkg::KIND_QUEUED;
                     state_in = srs_pkg::S_EMIT;
                  end
               end
               srs_pkg::OP_ACK:     state_in = srs_pkg::S_SUM;
               srs_pkg::OP_TIMEOUT: state_in = srs_pkg::S_T_SCAN;
               default:             state_in = srs_pkg::S_IDLE;
            endcase
         end
         srs_pkg::S_SUM: begin
            if (st.sum_last) begin
               if (drain_ff || st.op != srs_pkg::OP_ACK) state_in = srs_pkg::S_FOLD_SEQ;
               else state_in = srs_pkg::S_FOLD_SEQN;
            end
         end
         srs_pkg::S_FOLD_SEQ: begin
            kind_in  = (drain_ff || st.op == srs_pkg::OP_MSG) ? srs_pkg::KIND_SEND
                                                              : srs_pkg::KIND_RESEND;
            state_in = srs_pkg::S_EMIT;
         end
         srs_pkg::S_FOLD_SEQN: state_in = srs_pkg::S_FOLD_ACKN;
         srs_pkg::S_FOLD_ACKN: state_in = srs_pkg::S_FOLD_PCKS;
         srs_pkg::S_FOLD_PCKS: state_in = srs_pkg::S_CHECK;
         srs_pkg::S_CHECK: begin
            if (st.ack_good) begin
               state_in = srs_pkg::S_ACK_SCAN;
            end else begin
               kind_in  = srs_pkg::KIND_CORRUPT;
               state_in = srs_pkg::S_EMIT;
            end
         end
         srs_pkg::S_ACK_SCAN: begin
            if (st.scan_done || st.scan_hit) begin
               kind_in     = srs_pkg::KIND_ACK;
               ack_base_in = st.base_eq;
               state_in    = st.base_eq ? srs_pkg::S_SLIDE : srs_pkg::S_EMIT;
            end
         end
         srs_pkg::S_SLIDE: begin
            if (!st.slide_ok) state_in = srs_pkg::S_EMIT;
         end
         srs_pkg::S_T_SCAN: begin
            if (st.scan_hit) begin
               state_in = srs_pkg::S_T_LOAD;
            end else if (st.scan_done) begin
               kind_in  = srs_pkg::KIND_UNMATCHED;
               state_in = srs_pkg::S_EMIT;
            end
         end
         srs_pkg::S_T_LOAD: state_in = srs_pkg::S_SUM;
         srs_pkg::S_Q_READ: begin
            drain_in = 1'b1;
            state_in = srs_pkg::S_Q_LOAD;
         end
         srs_pkg::S_Q_LOAD: state_in = srs_pkg::S_SUM;
         srs_pkg::S_EMIT: begin
            if (st.out_free) state_in = last ? srs_pkg::S_IDLE : srs_pkg::S_Q_READ;
         end
         default: state_in = srs_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.load_sel = srs_pkg::LOAD_NONE;
      cmd.fold_sel = srs_pkg::FOLD_NEXT;
      cmd.kind     = kind_ff;
      cmd.last     = last;
      req_ready    = 1'b0;
      case (state_ff)
         srs_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.load_sel = srs_pkg::LOAD_INPUT;
         end
         srs_pkg::S_SUM: cmd.sum_step = 1'b1;
         srs_pkg::S_FOLD_SEQ: begin
            cmd.fold     = 1'b1;
            cmd.fold_sel = (drain_ff || st.op == srs_pkg::OP_MSG) ? srs_pkg::FOLD_NEXT
                                                                  : srs_pkg::FOLD_TSEQ;
         end
         srs_pkg::S_FOLD_SEQN: begin
            cmd.fold     = 1'b1;
            cmd.fold_sel = srs_pkg::FOLD_SEQN;
         end
         srs_pkg::S_FOLD_ACKN: begin
            cmd.fold     = 1'b1;
            cmd.fold_sel = srs_pkg::FOLD_ACKN;
         end
         srs_pkg::S_FOLD_PCKS: begin
            cmd.fold     = 1'b1;
            cmd.fold_sel = srs_pkg::FOLD_PCKS;
         end
         srs_pkg::S_ACK_SCAN: begin
            cmd.scan_step = !st.scan_done && !st.scan_hit;
            cmd.mark_ack  = st.scan_hit;
         end
         srs_pkg::S_SLIDE: cmd.slide = st.slide_ok;
         srs_pkg::S_T_SCAN: cmd.scan_step = !st.scan_done && !st.scan_hit;
         srs_pkg::S_T_LOAD: cmd.load_sel = srs_pkg::LOAD_SLOT;
         srs_pkg::S_Q_READ: cmd.q_pop = 1'b1;
         srs_pkg::S_Q_LOAD: cmd.load_sel = srs_pkg::LOAD_QUEUE;
         srs_pkg::S_EMIT: cmd.emit = st.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= srs_pkg::S_IDLE;
         kind_ff     <= srs_pkg::KIND_SEND;
         drain_ff    <= 1'b0;
         ack_base_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         kind_ff     <= kind_in;
         drain_ff    <= drain_in;
         ack_base_ff <= ack_base_in;
      end
   end

   a_drain_only_after_ack: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srs_pkg::S_Q_READ) |-> (st.op == srs_pkg::OP_ACK))
      else $error("queue drain outside of an acknowledgment");

   a_emit_from_emit_state: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (state_ff == srs_pkg::S_EMIT && st.out_free))
      else $error("result issued outside the emit state");

   a_queue_load_follows_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srs_pkg::S_Q_READ) |=> (state_ff == srs_pkg::S_Q_LOAD))
      else $error("queue read not followed by load");

endmodule
`default_nettype wire

@@ hw/rtl/srs_dp.sv @@
`default_nettype none
module srs_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [4:0]            csr_write_data,
   input  wire srs_pkg::req_item_type req_item,
   input  wire srs_pkg::cmd_type      cmd,
   output srs_pkg::status_type        st,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output srs_pkg::rsp_item_type      rsp_item
);

   logic [4:0]  window_ff;
   logic [4:0]  eff_window;

   logic [1:0]  op_ff;
   logic [15:0] seqn_ff, ackn_ff, pcks_ff, tseq_ff;
   logic [srs_pkg::PKT_W-1:0] pkt_ff;
   logic [15:0] acc_ff;
   logic [2:0]  sum_cnt_ff;

   logic [15:0] slot_seq_ff  [srs_pkg::MAX_WINDOW];
   logic [srs_pkg::PKT_W-1:0] slot_data_ff [srs_pkg::MAX_WINDOW];
   logic [srs_pkg::MAX_WINDOW-1:0] acked_ff;
   logic [15:0] base_ff, next_seq_ff;
   logic [srs_pkg::SLOT_AW-1:0] head_ff, tail_ff, scan_idx_ff;
   logic [srs_pkg::SLOT_AW:0]   in_flight_ff, scan_cnt_ff;

   logic [srs_pkg::PKT_W-1:0] queue_mem [srs_pkg::QUEUE_DEPTH];
   logic [srs_pkg::PKT_W-1:0] q_rdata_ff;
   logic [srs_pkg::QUEUE_AW-1:0] q_head_ff, q_tail_ff;
   logic [srs_pkg::QUEUE_AW:0]   q_count_ff;

   logic        rsp_valid_ff;
   srs_pkg::rsp_item_type rsp_ff, rsp_in;

   logic [15:0] fold_opnd;
   logic [16:0] fold_sum;
   logic [15:0] sum_add;
   logic [15:0] scan_key;
   logic        do_send, do_queue;

   always_comb begin
      if (window_ff == 5'd0) eff_window = 5'd1;
      else if (window_ff > 5'(srs_pkg::MAX_WINDOW)) eff_window = 5'(srs_pkg::MAX_WINDOW);
      else eff_window = window_ff;
   end

   assign scan_key = (op_ff == srs_pkg::OP_ACK) ? ackn_ff : tseq_ff;

   always_comb begin
      st               = '0;
      st.op            = op_ff;
      st.win_ok        = in_flight_ff < eff_window;
      st.q_full        = q_count_ff == (srs_pkg::QUEUE_AW+1)'(srs_pkg::QUEUE_DEPTH);
      st.sum_last      = sum_cnt_ff == 3'(srs_pkg::SUM_GROUPS - 1);
      st.ack_good      = acc_ff == srs_pkg::CKS_GOOD;
      st.scan_done     = scan_cnt_ff == in_flight_ff;
      st.scan_hit      = !st.scan_done && slot_seq_ff[scan_idx_ff] == scan_key;
      st.base_eq       = ackn_ff == base_ff;
      st.slide_ok      = in_flight_ff != '0 && acked_ff[head_ff];
      st.drain_pending = st.win_ok && q_count_ff != '0;
      st.drain_more    = (in_flight_ff + 1'b1) < eff_window && q_count_ff != '0;
      st.out_free      = !rsp_valid_ff || rsp_ready;
   end

   // Four payload bytes per step; the sum of twenty bytes stays below 2^16.
   always_comb begin
      sum_add = acc_ff;
      for (int b = 0; b < 4; b++) begin
         sum_add = sum_add + 16'(pkt_ff[32*sum_cnt_ff + 8*b +: 8]);
      end
   end

   always_comb begin
      case (cmd.fold_sel)
         srs_pkg::FOLD_NEXT: fold_opnd = next_seq_ff;
         srs_pkg::FOLD_TSEQ: fold_opnd = tseq_ff;
         srs_pkg::FOLD_SEQN: fold_opnd = seqn_ff;
         srs_pkg::FOLD_ACKN: fold_opnd = ackn_ff;
         srs_pkg::FOLD_PCKS: fold_opnd = pcks_ff;
         default:            fold_opnd = '0;
      endcase
      fold_sum = 17'(acc_ff) + 17'(fold_opnd);
   end

   assign do_send  = cmd.emit && cmd.kind == srs_pkg::KIND_SEND;
   assign do_queue = cmd.emit && cmd.kind == srs_pkg::KIND_QUEUED;

   always_comb begin
      rsp_in              = '0;
      rsp_in.kind         = cmd.kind;
      rsp_in.last         = cmd.last;
      rsp_in.window_base  = base_ff;
      case (cmd.kind)
         srs_pkg::KIND_SEND, srs_pkg::KIND_RESEND: begin
            rsp_in.seq_out      = (cmd.kind == srs_pkg::KIND_SEND) ? next_seq_ff : tseq_ff;
            rsp_in.checksum_out = ~acc_ff;
            rsp_in.data_low     = pkt_ff[63:0];
            rsp_in.data_mid     = pkt_ff[127:64];
            rsp_in.data_high    = pkt_ff[159:128];
         end
         srs_pkg::KIND_QUEUED:    rsp_in.seq_out = next_seq_ff + 16'(q_count_ff);
         srs_pkg::KIND_CORRUPT,
         srs_pkg::KIND_ACK:       rsp_in.seq_out = ackn_ff;
         srs_pkg::KIND_UNMATCHED: rsp_in.seq_out = tseq_ff;
         default:                 rsp_in.seq_out = '0;
      endcase
   end

   // Control and pointer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= srs_pkg::WINDOW_RESET;
         acked_ff     <= '0;
         base_ff      <= '0;
         next_seq_ff  <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         in_flight_ff <= '0;
         q_head_ff    <= '0;
         q_tail_ff    <= '0;
         q_count_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) window_ff <= csr_write_data;
         if (cmd.mark_ack) acked_ff[scan_idx_ff] <= 1'b1;
         if (cmd.slide) begin
            acked_ff[head_ff] <= 1'b0;
            head_ff      <= head_ff + 1'b1;
            base_ff      <= base_ff + 16'd1;
            in_flight_ff <= in_flight_ff - 1'b1;
         end
         if (do_send) begin
            acked_ff[tail_ff] <= 1'b0;
            tail_ff      <= tail_ff + 1'b1;
            in_flight_ff <= in_flight_ff + 1'b1;
            next_seq_ff  <= next_seq_ff + 16'd1;
         end
         if (do_queue) begin
            q_tail_ff  <= q_tail_ff + 1'b1;
            q_count_ff <= q_count_ff + 1'b1;
         end
         if (cmd.q_pop) begin
            q_head_ff  <= q_head_ff + 1'b1;
            q_count_ff <= q_count_ff - 1'b1;
         end
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      case (cmd.load_sel)
         srs_pkg::LOAD_INPUT: begin
            op_ff   <= req_item.op;
            seqn_ff <= req_item.seq_number;
            ackn_ff <= req_item.ack_number;
            pcks_ff <= req_item.packet_checksum;
            tseq_ff <= req_item.timeout_seq;
            pkt_ff  <= {req_item.payload_high, req_item.payload_mid, req_item.payload_low};
         end
         srs_pkg::LOAD_SLOT:  pkt_ff <= slot_data_ff[scan_idx_ff];
         srs_pkg::LOAD_QUEUE: pkt_ff <= q_rdata_ff;
         default: ;
      endcase
      if (cmd.load_sel != srs_pkg::LOAD_NONE) begin
         acc_ff     <= '0;
         sum_cnt_ff <= '0;
      end else if (cmd.sum_step) begin
         acc_ff     <= sum_add;
         sum_cnt_ff <= sum_cnt_ff + 3'd1;
      end else if (cmd.fold) begin
         acc_ff     <= fold_sum[15:0] + 16'(fold_sum[16]);
      end
      if (cmd.load_sel == srs_pkg::LOAD_INPUT) begin
         scan_idx_ff <= head_ff;
         scan_cnt_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
         scan_cnt_ff <= scan_cnt_ff + 1'b1;
      end
      if (do_send) begin
         slot_seq_ff[tail_ff]  <= next_seq_ff;
         slot_data_ff[tail_ff] <= pkt_ff;
      end
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (do_queue) begin
         queue_mem[q_tail_ff] <= pkt_ff;
      end
      if (cmd.q_pop) begin
         q_rdata_ff <= queue_mem[q_head_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_in_flight_bound: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff <= (srs_pkg::SLOT_AW+1)'(srs_pkg::MAX_WINDOW))
      else $error("more packets in flight than ring slots");

   a_ring_occupancy: assert property (@(posedge clock) disable iff (reset)
      (tail_ff - head_ff) == in_flight_ff[srs_pkg::SLOT_AW-1:0])
      else $error("ring pointers disagree with in-flight count");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.q_pop |-> (q_count_ff != '0))
      else $error("pop from empty queue");

endmodule
`default_nettype wire

@@ hw/rtl/selective_repeat_sender_core.sv @@
`default_nettype none
// Selective-repeat sender: one transaction on req_ch is a message (op 0), an acknowledgment
// packet (op 1) or a timer expiry (op 2); it yields one or more rsp_ch transactions, the last
// flagged by last. Items are handled one at a time by a shared 4-byte checksum adder and a
// one-slot-per-cycle ring scanner. An acknowledgment scans the in-flight slots, and when it
// matches the window base the window slides and queued messages are sent afterwards; a
// timeout scans the in-flight slots and resends the matching one. A result held by the
// receiver stalls the block. A new transaction is taken while the last result still waits.
// The user must write window_size through csr_write_enable only while the block is idle;
// the block itself does not enforce this.
module selective_repeat_sender_core (
   input  wire logic       clock,
   input  wire logic       reset,
   srs_req_if.sink         req_ch,
   srs_rsp_if.source       rsp_ch,
   input  wire logic       csr_write_enable,
   input  wire logic [4:0] csr_write_data
);

   srs_pkg::cmd_type      cmd;
   srs_pkg::status_type   st;
   srs_pkg::req_item_type req_item;
   srs_pkg::rsp_item_type rsp_item;
   logic                  ready;

   assign req_item.op              = req_ch.op;
   assign req_item.seq_number      = req_ch.seq_number;
   assign req_item.ack_number      = req_ch.ack_number;
   assign req_item.packet_checksum = req_ch.packet_checksum;
   assign req_item.timeout_seq     = req_ch.timeout_seq;
   assign req_item.payload_low     = req_ch.payload_low;
   assign req_item.payload_mid     = req_ch.payload_mid;
   assign req_item.payload_high    = req_ch.payload_high;
   assign req_ch.ready             = ready;

   srs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .st        (st),
      .cmd       (cmd)
   );

   srs_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_item         (req_item),
      .cmd              (cmd),
      .st               (st),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_item         (rsp_item)
   );

   assign rsp_ch.kind         = rsp_item.kind;
   assign rsp_ch.seq_out      = rsp_item.seq_out;
   assign rsp_ch.checksum_out = rsp_item.checksum_out;
   assign rsp_ch.data_low     = rsp_item.data_low;
   assign rsp_ch.data_mid     = rsp_item.data_mid;
   assign rsp_ch.data_high    = rsp_item.data_high;
   assign rsp_ch.window_base  = rsp_item.window_base;
   assign rsp_ch.last         = rsp_item.last;

endmodule
`default_nettype wire

@@ dv/srs_checker.sv @@
`timescale 1ns / 1ps
module srs_checker
   import srs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   srs_req_if               req_ch,
   srs_rsp_if               rsp_ch,
   input  wire logic        csr_write_enable,
   input  wire logic [4:0]  csr_write_data,
   output int               fail_count,
   output int               pending,
   output logic [15:0]      base_view,
   output logic [10:0]      queue_view
);

   logic [4:0]  window_reg;
   logic [15:0] slot_seq [MAX_WINDOW];
   logic [63:0] slot_low [MAX_WINDOW];
   logic [63:0] slot_mid [MAX_WINDOW];
   logic [31:0] slot_high [MAX_WINDOW];
   logic        slot_acked [MAX_WINDOW];
   logic [15:0] base_seq, next_seq;
   logic [3:0]  ring_head, ring_tail;
   logic [4:0]  in_flight;
   logic [63:0] wait_low [QUEUE_DEPTH];
   logic [63:0] wait_mid [QUEUE_DEPTH];
   logic [31:0] wait_high [QUEUE_DEPTH];
   logic [9:0]  wait_head, wait_tail;
   logic [10:0] wait_count;
   rsp_item_type expected_rsp [$];

   assign pending    = expected_rsp.size();
   assign base_view  = base_seq;
   assign queue_view = wait_count;

   function automatic logic [15:0] fold16(logic [31:0] s);
      while (s[31:16] != 0) s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      return s[15:0];
   endfunction

   function automatic logic [15:0] payload_sum(logic [63:0] lo, logic [63:0] mid,
                                               logic [31:0] hi);
      logic [31:0] s;
      s = 0;
      for (int i = 0; i < 8; i++) s += lo[8*i +: 8] + mid[8*i +: 8];
      for (int i = 0; i < 4; i++) s += hi[8*i +: 8];
      return fold16(s);
   endfunction

   function automatic logic [4:0] live_window();
      if (window_reg == 0) return 5'd1;
      if (window_reg > MAX_WINDOW) return 5'(MAX_WINDOW);
      return window_reg;
   endfunction

   task automatic note_result(logic [2:0] kind, logic [15:0] seq, logic [15:0] cks,
                              logic [63:0] dl, logic [63:0] dm, logic [31:0] dh);
      rsp_item_type r;
      r = '{kind: kind, seq_out: seq, checksum_out: cks, data_low: dl, data_mid: dm,
            data_high: dh, window_base: base_seq, last: 1'b0};
      expected_rsp.push_back(r);
   endtask

   task automatic launch(logic [63:0] dl, logic [63:0] dm, logic [31:0] dh);
      logic [15:0] cks;
      cks = ~fold16({16'd0, payload_sum(dl, dm, dh)} + {16'd0, next_seq});
      slot_seq[ring_tail]   = next_seq;
      slot_low[ring_tail]   = dl;
      slot_mid[ring_tail]   = dm;
      slot_high[ring_tail]  = dh;
      slot_acked[ring_tail] = 1'b0;
      ring_tail++;
      in_flight++;
      note_result(KIND_SEND, next_seq, cks, dl, dm, dh);
      next_seq++;
   endtask

   task automatic predict(req_item_type it);
      int size_at_start;
      logic [15:0] s, cks;
      logic [3:0] idx;
      logic hit;
      size_at_start = expected_rsp.size();
      case (it.op)
         OP_MSG: begin
            if (in_flight < live_window()) begin
               launch(it.payload_low, it.payload_mid, it.payload_high);
            end else if (wait_count < QUEUE_DEPTH) begin
               wait_low[wait_tail]  = it.payload_low;
               wait_mid[wait_tail]  = it.payload_mid;
               wait_high[wait_tail] = it.payload_high;
               wait_tail++;
               wait_count++;
               note_result(KIND_QUEUED, next_seq + 16'(wait_count) - 16'd1, 0, 0, 0, 0);
            end else begin
               note_result(KIND_DROPPED, 0, 0, 0, 0, 0);
            end
         end
         OP_ACK: begin
            s = payload_sum(it.payload_low, it.payload_mid, it.payload_high);
            s = fold16({16'd0, s} + {16'd0, it.seq_number});
            s = fold16({16'd0, s} + {16'd0, it.ack_number});
            s = fold16({16'd0, s} + {16'd0, it.packet_checksum});
            if (s != CKS_GOOD) begin
               note_result(KIND_CORRUPT, it.ack_number, 0, 0, 0, 0);
            end else begin
               idx = ring_head;
               for (int i = 0; i < in_flight; i++) begin
                  if (slot_seq[idx] == it.ack_number) begin
                     slot_acked[idx] = 1'b1;
                     break;
                  end
                  idx++;
               end
               if (it.ack_number == base_seq) begin
                  while (in_flight > 0 && slot_acked[ring_head]) begin
                     slot_acked[ring_head] = 1'b0;
                     ring_head++;
                     base_seq++;
                     in_flight--;
                  end
                  note_result(KIND_ACK, it.ack_number, 0, 0, 0, 0);
                  while (in_flight < live_window() && wait_count > 0) begin
                     idx = 0;
                     wait_count--;
                     launch(wait_low[wait_head], wait_mid[wait_head], wait_high[wait_head]);
                     wait_head++;
                  end
               end else begin
                  note_result(KIND_ACK, it.ack_number, 0, 0, 0, 0);
               end
            end
         end
         OP_TIMEOUT: begin
            hit = 1'b0;
            idx = ring_head;
            for (int i = 0; i < in_flight; i++) begin
               if (slot_seq[idx] == it.timeout_seq) begin
                  cks = ~fold16({16'd0, payload_sum(slot_low[idx], slot_mid[idx],
                                 slot_high[idx])} + {16'd0, it.timeout_seq});
                  note_result(KIND_RESEND, it.timeout_seq, cks, slot_low[idx],
                              slot_mid[idx], slot_high[idx]);
                  hit = 1'b1;
                  break;
               end
               idx++;
            end
            if (!hit) note_result(KIND_UNMATCHED, it.timeout_seq, 0, 0, 0, 0);
         end
         default: ;
      endcase
      if (expected_rsp.size() > size_at_start) expected_rsp[$].last = 1'b1;
   endtask

   task automatic compare(rsp_item_type got);
      rsp_item_type exp;
      if (expected_rsp.size() == 0) begin
         $error("result transaction with nothing expected: kind %0d seq %0d",
                got.kind, got.seq_out);
         fail_count++;
         return;
      end
      exp = expected_rsp.pop_front();
      if (got.kind != exp.kind) begin
         $error("kind: expected %0d, got %0d", exp.kind, got.kind); fail_count++;
      end
      if (got.seq_out != exp.seq_out) begin
         $error("seq_out: expected %0d, got %0d", exp.seq_out, got.seq_out); fail_count++;
      end
      if (got.checksum_out != exp.checksum_out) begin
         $error("checksum_out: expected %h, got %h", exp.checksum_out, got.checksum_out);
         fail_count++;
      end
      if (got.data_low != exp.data_low) begin
         $error("data_low: expected %h, got %h", exp.data_low, got.data_low); fail_count++;
      end
      if (got.data_mid != exp.data_mid) begin
         $error("data_mid: expected %h, got %h", exp.data_mid, got.data_mid); fail_count++;
      end
      if (got.data_high != exp.data_high) begin
         $error("data_high: expected %h, got %h", exp.data_high, got.data_high); fail_count++;
      end
      if (got.window_base != exp.window_base) begin
         $error("window_base: expected %0d, got %0d", exp.window_base, got.window_base);
         fail_count++;
      end
      if (got.last != exp.last) begin
         $error("last: expected %0d, got %0d", exp.last, got.last); fail_count++;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         window_reg = WINDOW_RESET;
         for (int i = 0; i < MAX_WINDOW; i++) slot_acked[i] = 1'b0;
         base_seq   = 0;
         next_seq   = 0;
         ring_head  = 0;
         ring_tail  = 0;
         in_flight  = 0;
         wait_head  = 0;
         wait_tail  = 0;
         wait_count = 0;
         expected_rsp.delete();
      end else begin
         // Results are checked before the new request adds its own expectations.
         if (rsp_ch.valid && rsp_ch.ready)
            compare('{kind: rsp_ch.kind, seq_out: rsp_ch.seq_out,
                      checksum_out: rsp_ch.checksum_out, data_low: rsp_ch.data_low,
                      data_mid: rsp_ch.data_mid, data_high: rsp_ch.data_high,
                      window_base: rsp_ch.window_base, last: rsp_ch.last});
         if (req_ch.valid && req_ch.ready)
            predict('{op: req_ch.op, seq_number: req_ch.seq_number,
                      ack_number: req_ch.ack_number,
                      packet_checksum: req_ch.packet_checksum,
                      timeout_seq: req_ch.timeout_seq, payload_low: req_ch.payload_low,
                      payload_mid: req_ch.payload_mid, payload_high: req_ch.payload_high});
         if (csr_write_enable) window_reg = csr_write_data;
      end
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import srs_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable;
   logic [4:0] csr_write_data;
   int fail_count, pending, cycle_count;
   logic [15:0] base_view;
   logic [10:0] queue_view;
   bit hold_rsp, steady;
   int rsp_wait;

   srs_req_if req_ch ();
   srs_rsp_if rsp_ch ();

   selective_repeat_sender_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   srs_checker scoreboard (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending(pending), .base_view(base_view),
      .queue_view(queue_view)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Result side: a random stall after each transaction, or one long hold-off on request.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
            rsp_ch.ready <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ch.ready <= (rsp_wait == 0);
         end else if (rsp_ch.valid && rsp_ch.ready && !steady) begin
            rsp_wait = $urandom_range(0, 4);
            rsp_ch.ready <= (rsp_wait == 0);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic logic [15:0] ones_sum(logic [63:0] lo, logic [63:0] mid,
                                            logic [31:0] hi, logic [15:0] a, logic [15:0] b);
      logic [31:0] s;
      s = a + b;
      for (int i = 0; i < 8; i++) s += lo[8*i +: 8] + mid[8*i +: 8];
      for (int i = 0; i < 4; i++) s += hi[8*i +: 8];
      while (s[31:16] != 0) s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      return s[15:0];
   endfunction

   function automatic req_item_type random_item(logic [1:0] op);
      req_item_type it;
      it.op = op;
      it.seq_number = $urandom;
      it.ack_number = $urandom;
      it.packet_checksum = $urandom;
      it.timeout_seq = $urandom;
      it.payload_low = {$urandom, $urandom};
      it.payload_mid = {$urandom, $urandom};
      it.payload_high = $urandom;
      return it;
   endfunction

   function automatic req_item_type good_ack(logic [15:0] ackn);
      req_item_type it;
      it = random_item(OP_ACK);
      it.ack_number = ackn;
      it.packet_checksum = ~ones_sum(it.payload_low, it.payload_mid, it.payload_high,
                                     it.seq_number, ackn);
      return it;
   endfunction

   function automatic req_item_type timeout_for(logic [15:0] t);
      req_item_type it;
      it = random_item(OP_TIMEOUT);
      it.timeout_seq = t;
      return it;
   endfunction

   task automatic offer(req_item_type it);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= it.op;
      req_ch.seq_number <= it.seq_number;
      req_ch.ack_number <= it.ack_number;
      req_ch.packet_checksum <= it.packet_checksum;
      req_ch.timeout_seq <= it.timeout_seq;
      req_ch.payload_low <= it.payload_low;
      req_ch.payload_mid <= it.payload_mid;
      req_ch.payload_high <= it.payload_high;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // A request without results may still be in the block.
      repeat (60) @(posedge clock);
   endtask

   task automatic set_window(logic [4:0] w);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= w;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly acknowledgments and timeouts near the window, with well-formed checksums.
   task automatic random_phase(int count);
      req_item_type it;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) it = random_item(OP_MSG);
         else if (pick < 65) it = good_ack(base_view + 16'($urandom_range(0, 3)));
         else if (pick < 72) it = good_ack(base_view + 16'($urandom_range(0, 20)));
         else if (pick < 77) it = random_item(OP_ACK);
         else if (pick < 92) it = timeout_for(base_view + 16'($urandom_range(0, 17)));
         else if (pick < 97) it = random_item(OP_TIMEOUT);
         else it = random_item(2'd3);
         offer(it);
         if (n == count / 3) hold_rsp = 1;
         if (n == count / 2) steady = 1;
         if (n == count / 2 + 40) steady = 0;
      end
   endtask

   initial begin
      req_item_type it;
      logic [15:0] b;
      req_ch.valid <= 1'b0;
      req_ch.op <= OP_MSG;
      req_ch.seq_number <= '0;
      req_ch.ack_number <= '0;
      req_ch.packet_checksum <= '0;
      req_ch.timeout_seq <= '0;
      req_ch.payload_low <= '0;
      req_ch.payload_mid <= '0;
      req_ch.payload_high <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: payload extremes, every op, corrupt and unmatched cases.
      it = random_item(OP_MSG);
      it.payload_low = '0; it.payload_mid = '0; it.payload_high = '0;
      offer(it);
      it.payload_low = '1; it.payload_mid = '1; it.payload_high = '1;
      offer(it);
      offer(timeout_for(16'd1));
      offer(timeout_for(16'hFFFF));
      it = good_ack(16'd1);
      offer(it);
      it.packet_checksum = it.packet_checksum ^ 16'h0001;
      offer(it);
      offer(good_ack(16'd500));
      offer(good_ack(16'd0));
      offer(random_item(2'd3));
      for (int i = 0; i < 10; i++) offer(random_item(OP_MSG));
      offer(timeout_for(base_view + 16'd3));
      offer(good_ack(base_view + 16'd1));
      offer(good_ack(base_view));
      drain();

      set_window(5'd0);
      random_phase(70);
      set_window(5'd31);
      random_phase(70);
      set_window(5'd1);
      random_phase(50);
      set_window(5'(2 + $urandom_range(0, 13)));
      random_phase(70);

      // Back up the wait queue behind a window of one, then drain it sixteen at a time.
      set_window(5'd1);
      steady = 1;
      for (int i = 0; i < 40; i++) offer(random_item(OP_MSG));
      set_window(5'd16);
      while (queue_view != 0) begin
         b = base_view;
         for (int k = 15; k >= 0; k--) offer(good_ack(b + 16'(k)));
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while (pending != 0) @(posedge clock);
      end
      steady = 0;
      set_window(5'd16);
      random_phase(90);

      drain();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
